FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions of the double-ended queue
// Sizes, field types, operation codes and ring index helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Number of ring entries and the widths that follow from it.
   localparam int DEPTH  = 1024;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;

   typedef logic        [IDX_W-1:0]  idx_type;
   typedef logic        [CNT_W-1:0]  cnt_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic        [OP_W-1:0]   op_type;

   // Operation codes. Any other code acts as a query.
   localparam op_type OP_PUSH_BACK  = OP_W'(0);
   localparam op_type OP_PUSH_FRONT = OP_W'(1);
   localparam op_type OP_POP_BACK   = OP_W'(2);
   localparam op_type OP_POP_FRONT  = OP_W'(3);
   localparam op_type OP_QUERY      = OP_W'(4);

   // Step a ring index forward with wrap at DEPTH.
   function automatic idx_type idx_next(input idx_type i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_type'(i + 1'b1);
   endfunction

   // Step a ring index backward with wrap at DEPTH.
   function automatic idx_type idx_prev(input idx_type i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : idx_type'(i - 1'b1);
   endfunction

endpackage

FILE: rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if: request and response channels
// Valid/ready channels that carry one queue request or one response.
// ----------------------------------------------------------------------------
interface deq_req_if;
   import deq_pkg::*;

   logic     valid;
   logic     ready;
   op_type   op;
   data_type data_in;

   modport source (output valid, output op, output data_in, input ready);
   modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;

   logic     valid;
   logic     ready;
   data_type popped_value;
   data_type front_value;
   data_type back_value;
   cnt_type  item_count;
   logic     underflow;
   logic     overflow;

   modport source (output valid, output popped_value, output front_value,
                   output back_value, output item_count, output underflow,
                   output overflow, input ready);
   modport sink   (input valid, input popped_value, input front_value,
                   input back_value, input item_count, input underflow,
                   input overflow, output ready);
endinterface

FILE: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int WORDS = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [WORDS];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/double_ended_queue.sv
// Timing: a push, a query, or a pop that leaves or finds the queue empty responds in the
// cycle after acceptance; any other pop first passes through a ring read of the new end.
// Only one request is in flight: a new request is taken only once the response to the
// last one has been accepted and the block has returned to idle.
// Reset (synchronous): head, tail and count clear to zero and the queue is empty;
// ring contents are not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
// double_ended_queue: circular-buffer deque of signed 32-bit values
// Pushes and pops at either end; the end values are cached in registers and
// refreshed from the ring memory after a pop.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input logic       clock,
   input logic       reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff, state_in;
   idx_type    head_ff, head_in;
   idx_type    tail_ff, tail_in;
   cnt_type    count_ff, count_in;
   data_type   front_ff, front_in;
   data_type   back_ff, back_in;
   data_type   popped_ff, popped_in;
   logic       under_ff, under_in;
   logic       over_ff, over_in;
   logic       read_front_ff, read_front_in;

   logic       accept;
   logic       full;
   logic       empty;
   idx_type    step_idx;

   logic       ram_wr_en;
   idx_type    ram_wr_addr;
   data_type   ram_wr_data;
   logic       ram_rd_en;
   idx_type    ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // Ring storage.
   deq_ram #(
      .WIDTH (DATA_W),
      .WORDS (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CNT_W'(DEPTH));
   assign empty          = (count_ff == '0);

   // Next-state logic: apply the request, then refresh an end value after a pop.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      popped_in     = popped_ff;
      under_in      = under_ff;
      over_in       = over_ff;
      read_front_in = read_front_ff;
      step_idx      = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = tail_ff;
      ram_wr_data   = req_chan.data_in;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               popped_in = '0;
               under_in  = 1'b0;
               over_in   = 1'b0;
               state_in  = ST_RESP;
               case (req_chan.op)
                  OP_PUSH_BACK: begin
                     if (full) begin
                        over_in = 1'b1;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tail_ff;
                        tail_in     = idx_next(tail_ff);
                        count_in    = cnt_type'(count_ff + 1'b1);
                        back_in     = req_chan.data_in;
                        if (empty) begin
                           front_in = req_chan.data_in;
                        end
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        over_in = 1'b1;
                     end else begin
                        step_idx    = idx_prev(head_ff);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = step_idx;
                        head_in     = step_idx;
                        count_in    = cnt_type'(count_ff + 1'b1);
                        front_in    = req_chan.data_in;
                        if (empty) begin
                           back_in = req_chan.data_in;
                        end
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        under_in = 1'b1;
                     end else begin
                        step_idx      = idx_prev(tail_ff);
                        popped_in     = back_ff;
                        tail_in       = step_idx;
                        count_in      = cnt_type'(count_ff - 1'b1);
                        read_front_in = 1'b0;
                        ram_rd_addr   = idx_prev(step_idx);
                        // Fetch the new back element when one remains.
                        if (count_ff != CNT_W'(1)) begin
                           ram_rd_en = 1'b1;
                           state_in  = ST_READ;
                        end
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        under_in = 1'b1;
                     end else begin
                        step_idx      = idx_next(head_ff);
                        popped_in     = front_ff;
                        head_in       = step_idx;
                        count_in      = cnt_type'(count_ff - 1'b1);
                        read_front_in = 1'b1;
                        ram_rd_addr   = step_idx;
                        // Fetch the new front element when one remains.
                        if (count_ff != CNT_W'(1)) begin
                           ram_rd_en = 1'b1;
                           state_in  = ST_READ;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (read_front_ff) begin
               front_in = data_type'(ram_rd_data);
            end else begin
               back_in = data_type'(ram_rd_data);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Cached end values and response payload.
   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      popped_ff     <= popped_in;
      under_ff      <= under_in;
      over_ff       <= over_in;
      read_front_ff <= read_front_in;
   end

   // Response channel; an empty queue shows zero at both ends.
   assign rsp_chan.valid        = (state_ff == ST_RESP);
   assign rsp_chan.popped_value = popped_ff;
   assign rsp_chan.front_value  = empty ? '0 : front_ff;
   assign rsp_chan.back_value   = empty ? '0 : back_ff;
   assign rsp_chan.item_count   = count_ff;
   assign rsp_chan.underflow    = under_ff;
   assign rsp_chan.overflow     = over_ff;

   // Checks on pointer and flow-control consistency.
   logic [CNT_W:0] ptr_sum;
   assign ptr_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count exceeds ring depth");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      (ptr_sum == (CNT_W+1)'(tail_ff)) ||
      (ptr_sum == (CNT_W+1)'(tail_ff) + (CNT_W+1)'(DEPTH)))
      else $error("head, tail and count disagree");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");

   a_underflow_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && empty && ((req_chan.op == OP_POP_BACK) ||
                           (req_chan.op == OP_POP_FRONT)))
      |=> (under_ff && (state_ff == ST_RESP)))
      else $error("pop from empty queue not flagged");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the double-ended queue
// A shadow deque follows every accepted request and predicts its response.
// Responses are compared field by field in order. Directed requests come first.
// Random requests follow in phases that work near empty, fill the ring to
// overflow, and drain it again. Both channels idle at random, and the sink
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
   import deq_pkg::*;

   // Spare operation codes, which the block treats as a query.
   localparam op_type OP_SPARE_LO  = OP_W'(5);
   localparam op_type OP_SPARE_MID = OP_W'(6);
   localparam op_type OP_SPARE_HI  = OP_W'(7);

   localparam data_type MOST_POS = 32'sh7fff_ffff;
   localparam data_type MOST_NEG = 32'sh8000_0000;

   localparam int QUIET_LIMIT  = 4000;  // cycles without any handshake
   localparam int LONG_HOLD    = 300;   // cycles of the long sink hold-off
   localparam int HOLD_AT      = 300;   // responses checked before that hold
   localparam int REPORT_LIMIT = 40;    // mismatch lines printed at most

   typedef struct {
      data_type popped_value;
      data_type front_value;
      data_type back_value;
      cnt_type  item_count;
      logic     underflow;
      logic     overflow;
   } deq_result_type;

   // Shadow deque: mirrors the ring on every accepted request and keeps the
   // responses that are still due, oldest first.
   class deque_mirror;
      data_type       ring [DEPTH];
      int             head;
      int             tail;
      int             fill;
      deq_result_type awaited [$];
      int             accepted;
      int             checked;
      int             errors;
      int             overflows;
      int             underflows;
      int             peak;

      function int slot_after(int i);
         return (i == DEPTH - 1) ? 0 : i + 1;
      endfunction

      function int slot_before(int i);
         return (i == 0) ? DEPTH - 1 : i - 1;
      endfunction

      // Apply one request to the shadow ring and queue its response.
      function void note_request(op_type op, data_type value);
         deq_result_type r;
         r.popped_value = '0;
         r.front_value  = '0;
         r.back_value   = '0;
         r.underflow    = 1'b0;
         r.overflow     = 1'b0;
         case (op)
            OP_PUSH_BACK: begin
               if (fill == DEPTH) begin
                  r.overflow = 1'b1;
               end else begin
                  ring[tail] = value;
                  tail = slot_after(tail);
                  fill++;
               end
            end
            OP_PUSH_FRONT: begin
               if (fill == DEPTH) begin
                  r.overflow = 1'b1;
               end else begin
                  head = slot_before(head);
                  ring[head] = value;
                  fill++;
               end
            end
            OP_POP_BACK: begin
               if (fill == 0) begin
                  r.underflow = 1'b1;
               end else begin
                  tail = slot_before(tail);
                  r.popped_value = ring[tail];
                  fill--;
               end
            end
            OP_POP_FRONT: begin
               if (fill == 0) begin
                  r.underflow = 1'b1;
               end else begin
                  r.popped_value = ring[head];
                  head = slot_after(head);
                  fill--;
               end
            end
            default: begin
            end
         endcase
         // The end values are read from the ring after the update.
         if (fill != 0) begin
            r.front_value = ring[head];
            r.back_value  = ring[slot_before(tail)];
         end
         r.item_count = cnt_type'(fill);
         if (r.overflow) overflows++;
         if (r.underflow) underflows++;
         if (fill > peak) peak = fill;
         accepted++;
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, logic signed [DATA_W:0] want,
                                  logic signed [DATA_W:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("[%0t] %s mismatch on response %0d: expected %0d, actual %0d",
                        $time, name, checked, want, got);
         end
      endfunction

      // Compare one response with the oldest one still due.
      function void check_response(deq_result_type got);
         deq_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("[%0t] response with none due: expected nothing, actual count %0d",
                        $time, got.item_count);
            return;
         end
         want = awaited.pop_front();
         compare_field("popped_value", want.popped_value, got.popped_value);
         compare_field("front_value", want.front_value, got.front_value);
         compare_field("back_value", want.back_value, got.back_value);
         compare_field("item_count", want.item_count, got.item_count);
         compare_field("underflow", want.underflow, got.underflow);
         compare_field("overflow", want.overflow, got.overflow);
         checked++;
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;       // no idling on either side
   bit   hold_done;  // the long sink hold-off has happened
   bit   finished;

   deque_mirror mirror = new;

   deq_req_if req_chan ();
   deq_rsp_if rsp_chan ();

   double_ended_queue u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock and known input values from time zero.
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.op      = OP_QUERY;
      req_chan.data_in = '0;
      rsp_chan.ready   = 1'b0;
   end

   always #5 clock = ~clock;

   // Random value with the extremes weighted in.
   function automatic data_type random_value();
      case ($urandom_range(0, 9))
         0: return MOST_POS;
         1: return MOST_NEG;
         2: return '0;
         3: return '1;
         default: return data_type'($urandom);
      endcase
   endfunction

   // Pick an operation: pushes and pops by percentage, the rest are queries.
   function automatic op_type pick_op(int push_pct, int pop_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      if (roll < push_pct + pop_pct)
         return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      return op_type'($urandom_range(int'(OP_QUERY), int'(OP_SPARE_HI)));
   endfunction

   // Offer one request, at times after a random gap, and hold it until accepted.
   task automatic send_request(op_type op, data_type value);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.op      <= op;
      req_chan.data_in <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      mirror.note_request(op, value);
   endtask

   task automatic run_mix(int count, int push_pct, int pop_pct);
      repeat (count) send_request(pick_op(push_pct, pop_pct), random_value());
   endtask

   // Stop offering until every response due has come back.
   task automatic wait_all_answered();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (mirror.awaited.size() != 0);
   endtask

   // Sink pacing: random ready bursts and stalls, one long hold-off.
   initial begin : sink_pacing
      while (reset) @(posedge clock);
      forever begin
         if (calm) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else if (!hold_done && mirror.checked >= HOLD_AT) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin : rsp_monitor
      deq_result_type seen;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen.popped_value = rsp_chan.popped_value;
         seen.front_value  = rsp_chan.front_value;
         seen.back_value   = rsp_chan.back_value;
         seen.item_count   = rsp_chan.item_count;
         seen.underflow    = rsp_chan.underflow;
         seen.overflow     = rsp_chan.overflow;
         mirror.check_response(seen);
      end
   end

   // Watchdog: ends the run when no handshake happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (!finished && quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      if (!finished) begin
         $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("double_ended_queue verification failed");
         $finish;
      end
   end

   // Stimulus.
   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pops, extremes at both ends, spare codes, wrap of
      // the head below slot zero, and emptying the queue from either end.
      send_request(OP_QUERY, '0);
      send_request(OP_POP_BACK, '0);
      send_request(OP_POP_FRONT, '1);
      send_request(OP_PUSH_BACK, MOST_POS);
      send_request(OP_PUSH_FRONT, MOST_NEG);
      send_request(OP_PUSH_BACK, '0);
      send_request(OP_PUSH_FRONT, '1);
      send_request(OP_SPARE_LO, random_value());
      send_request(OP_SPARE_MID, random_value());
      send_request(OP_SPARE_HI, random_value());
      send_request(OP_POP_FRONT, random_value());
      send_request(OP_POP_BACK, random_value());
      send_request(OP_PUSH_BACK, 32'sd1);
      send_request(OP_POP_BACK, '0);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, '0);
      send_request(OP_PUSH_FRONT, 32'sh5555_5555);
      send_request(OP_POP_BACK, '0);
      wait_all_answered();

      // Near empty: both indexes wrap back and forth across slot zero.
      run_mix(100, 45, 45);

      // Fill to full, then try pushes against the full ring.
      while (mirror.fill < DEPTH) send_request(pick_op(92, 4), random_value());
      run_mix(30, 80, 10);
      wait_all_answered();

      // Drain part of the way.
      run_mix(300, 20, 75);

      // Last stretch with both sides running flat out.
      calm = 1'b1;
      run_mix(120, 45, 45);
      wait_all_answered();
      repeat (8) @(posedge clock);
      finished = 1'b1;

      $display("Run covered %0d requests and %0d checked responses, peak fill %0d of %0d,",
               mirror.accepted, mirror.checked, mirror.peak, DEPTH);
      $display("with %0d dropped pushes and %0d empty pops; %0d mismatches.",
               mirror.overflows, mirror.underflows, mirror.errors);
      if (mirror.errors == 0 && mirror.awaited.size() == 0)
         $display("double_ended_queue verification clean");
      else
         $display("double_ended_queue verification failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_ram.sv
rtl/double_ended_queue.sv
verif/tb.sv
